// ----- hw/rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants
// Widths, controller states, and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CounterBitsDef = 16;
    localparam int ClkW           = 32;
    localparam int FreqW          = 40;
    localparam int ValW           = 16;
    localparam int DivW           = 80;   // dividend / divisor width
    localparam int QuotW          = 48;   // quotient width kept
    localparam int DivCntW        = 7;    // counts up to DivW
    localparam int IterW          = 7;    // counts up to SearchLimit
    localparam int SearchLimit    = 64;
    localparam logic [ValW-1:0] Mask16 = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST,
        ST_SLOW,
        ST_SLOW_W,
        ST_MID,
        ST_MID_W,
        ST_TEST,
        ST_RLD,
        ST_RLD_W,
        ST_CMP,
        ST_CMP_W,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        DV_SLOW,
        DV_MID,
        DV_RLD,
        DV_CMP
    } t_div_sel;

    typedef enum logic [2:0] {
        RS_FAST,
        RS_MAX,
        RS_SLOW,
        RS_EQ,
        RS_LOW,
        RS_HIGH
    } t_res_sel;

    typedef struct packed {
        logic     load;       // capture input item
        logic     div_start;
        t_div_sel div_sel;
        logic     set_res;
        t_res_sel res_sel;
        logic     step;       // apply search step from last compare
        logic     rld_done;   // take reload quotient
        logic     cmp_done;   // take compare quotient
    } t_cmd;

    typedef struct packed {
        logic is_fast;
        logic is_slow;
        logic le_minq;    // at or below the lowest frequency
        logic div_busy;
        logic g_gt;
        logic g_lt;
        logic bounds_close; // after step
        logic loop_ok;      // low <= high
        logic orl_zero;
        logic oc_ge_orl;
    } t_status;

endpackage

// ----- hw/rtl/pps_if.sv -----
// ----------------------------------------------------------------------------
// pps_if: valid/ready channel
// Generic handshake channel carrying one payload item.
// ----------------------------------------------------------------------------
interface pps_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pps_div.sv -----
// ----------------------------------------------------------------------------
// pps_div: restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pps_pkg::DivW-1:0] i_num,
    input  logic [pps_pkg::DivW-1:0] i_den,
    output logic                     o_busy,
    output logic [pps_pkg::QuotW-1:0] o_quot
);
    import pps_pkg::*;

    logic [DivW-1:0]    r_rem, n_rem;
    logic [DivW-1:0]    r_num, n_num;
    logic [DivW-1:0]    r_den;
    logic [DivW-1:0]    r_q, n_q;
    logic [DivCntW-1:0] r_cnt;
    logic               r_busy;
    logic [DivW:0]      w_trial;

    always_comb begin
        w_trial = {r_rem, r_num[DivW-1]};
        n_rem   = w_trial[DivW-1:0];
        n_q     = {r_q[DivW-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = DivW'(w_trial - {1'b0, r_den});
            n_q[0] = 1'b1;
        end
        n_num = {r_num[DivW-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DivCntW'(DivW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DivCntW'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_q   <= n_q;
        end
    end

    assign o_busy = r_busy;
    // divisor zero gives all ones, results saturate downstream
    assign o_quot = (r_q[DivW-1:QuotW] != '0) ? '1 : r_q[QuotW-1:0];
endmodule

// ----- hw/rtl/pps_ctrl.sv -----
// ----------------------------------------------------------------------------
// pps_ctrl: solver sequencer
// Walks the case tests, search loop and compare rescale for one item.
// ----------------------------------------------------------------------------
module pps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  pps_pkg::t_status  i_sts,
    output pps_pkg::t_cmd     o_cmd
);
    import pps_pkg::*;

    t_state           r_state, n_state;
    logic [IterW-1:0] r_iter, n_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_FAST;
                end
            end
            ST_FAST: begin
                n_iter = '0;
                if (i_sts.is_fast) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RS_FAST;
                    n_state       = ST_CMP;
                end else if (i_sts.is_slow) begin
                    if (i_sts.le_minq) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_sel = RS_MAX;
                        n_state       = ST_CMP;
                    end else begin
                        n_state = ST_SLOW;
                    end
                end else begin
                    n_state = ST_MID;
                end
            end
            ST_SLOW: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_SLOW;
                n_state         = ST_SLOW_W;
            end
            ST_SLOW_W: begin
                if (!i_sts.div_busy) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RS_SLOW;
                    n_state       = ST_CMP;
                end
            end
            ST_MID: begin
                if (r_iter == IterW'(SearchLimit) || !i_sts.loop_ok) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RS_HIGH;
                    n_state       = ST_RLD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DV_MID;
                    n_state         = ST_MID_W;
                end
            end
            ST_MID_W: begin
                if (!i_sts.div_busy) begin
                    if (!i_sts.g_gt && !i_sts.g_lt) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res_sel = RS_EQ;
                        n_state       = ST_CMP;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_iter     = r_iter + 1'b1;
                        n_state    = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                if (i_sts.bounds_close) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_sel = RS_LOW;
                    n_state       = ST_RLD;
                end else begin
                    n_state = ST_MID;
                end
            end
            ST_RLD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_RLD;
                n_state         = ST_RLD_W;
            end
            ST_RLD_W: begin
                if (!i_sts.div_busy) begin
                    o_cmd.rld_done = 1'b1;
                    n_state        = ST_CMP;
                end
            end
            ST_CMP: begin
                if (i_sts.orl_zero || i_sts.oc_ge_orl) begin
                    n_state = ST_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DV_CMP;
                    n_state         = ST_CMP_W;
                end
            end
            ST_CMP_W: begin
                if (!i_sts.div_busy) begin
                    o_cmd.cmp_done = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= IterW'(SearchLimit))
        else $error("search iteration count overran");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");
endmodule

// ----- hw/rtl/pps_dp.sv -----
// ----------------------------------------------------------------------------
// pps_dp: solver datapath
// Item registers, search bounds, shared divider and result registers.
// ----------------------------------------------------------------------------
module pps_dp #(
    parameter int COUNTER_BITS = pps_pkg::CounterBitsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pps_pkg::ClkW-1:0]   i_clk_hz,
    input  logic [pps_pkg::FreqW-1:0]  i_target_freq,
    input  logic [pps_pkg::ValW-1:0]   i_old_compare,
    input  logic [pps_pkg::ValW-1:0]   i_old_reload,
    input  pps_pkg::t_cmd              i_cmd,
    output pps_pkg::t_status           o_sts,
    output logic [pps_pkg::ValW-1:0]   o_prescaler,
    output logic [pps_pkg::ValW-1:0]   o_reload,
    output logic [pps_pkg::ValW-1:0]   o_new_compare
);
    import pps_pkg::*;

    localparam int MinqW = FreqW + COUNTER_BITS + 2;

    logic [ClkW-1:0]  r_c;
    logic [FreqW-1:0] r_t;
    logic [ValW-1:0]  r_oc, r_orl;
    logic [31:0]      r_low, r_high, r_mid;
    logic [ValW-1:0]  r_psc, r_arr, r_cmp;

    logic [DivW-1:0]  w_num, w_den;
    logic [QuotW-1:0] w_quot;
    logic             w_busy;
    logic [ClkW-1:0]  w_slow;
    logic [ClkW-1:0]  w_c10;
    logic [DivW-1:0]  w_g256;
    logic [32:0]      w_sum;
    logic [QuotW-1:0] w_qm1;
    logic [67:0]      w_recip;
    logic [ClkW-1:0]  w_qe;
    logic [MinqW-1:0] w_minq_num;
    logic [MinqW-1:0] w_t_span;

    assign w_slow = r_c >> COUNTER_BITS;
    // divide by ten via multiply by reciprocal
    assign w_recip = {36'd0, r_c} * 68'hCCCCCCCD;
    assign w_qe    = ClkW'(w_recip >> 35);
    assign w_c10   = w_qe;

    // t <= floor(n / (span + 2)) is the same as t * (span + 2) <= n
    assign w_minq_num = MinqW'({r_c, 8'd0} >> COUNTER_BITS);
    assign w_t_span   = (MinqW'(r_t) << COUNTER_BITS) + (MinqW'(r_t) << 1);

    always_comb begin
        w_num = '0;
        w_den = '0;
        case (i_cmd.div_sel)
            DV_SLOW: begin
                w_num = DivW'(r_c);
                w_den = DivW'({r_t, 8'd0});
            end
            DV_MID: begin
                w_num = DivW'(w_slow);
                w_den = DivW'({1'b0, r_mid} + 33'd1);
            end
            DV_RLD: begin
                w_num = DivW'({r_c, 8'd0});
                w_den = DivW'(r_t) * DivW'({1'b0, r_psc} + 17'd1);
            end
            DV_CMP: begin
                w_num = DivW'(r_arr) * DivW'(r_oc);
                w_den = DivW'(r_orl);
            end
            default: ;
        endcase
    end

    pps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quot  (w_quot)
    );

    assign w_g256 = {32'd0, w_quot} << 8;
    assign w_sum  = {1'b0, r_low} + {1'b0, r_high};
    assign w_qm1  = w_quot - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c    <= i_clk_hz;
            r_t    <= i_target_freq;
            r_oc   <= i_old_compare;
            r_orl  <= i_old_reload;
            r_low  <= '0;
            r_high <= 32'h0000FFFF;
        end
        if (i_cmd.div_start && i_cmd.div_sel == DV_MID) r_mid <= w_sum[32:1];
        if (i_cmd.step) begin
            if (w_g256 > DivW'(r_t)) r_low <= r_mid + 32'd1;
            else r_high <= r_mid - 32'd1;
        end
        if (i_cmd.set_res) begin
            case (i_cmd.res_sel)
                RS_FAST: begin r_psc <= '0; r_arr <= 16'd9; end
                RS_MAX:  begin r_psc <= Mask16; r_arr <= Mask16; end
                RS_SLOW: begin
                    r_arr <= Mask16;
                    if (w_quot == '0) r_psc <= '0;
                    else if (w_qm1 > QuotW'(Mask16)) r_psc <= Mask16;
                    else r_psc <= w_qm1[ValW-1:0];
                end
                RS_EQ:   begin r_psc <= r_mid[ValW-1:0]; r_arr <= Mask16; end
                RS_LOW:  r_psc <= r_low[ValW-1:0];
                RS_HIGH: r_psc <= r_high[ValW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.rld_done) r_arr <= w_qm1[ValW-1:0];
        if (i_cmd.cmp_done) r_cmp <= w_quot[ValW-1:0];
    end

    assign o_sts.is_fast      = {8'd0, r_t} >= {w_c10, 8'd0};
    assign o_sts.is_slow      = {8'd0, r_t} <= {w_slow, 8'd0};
    assign o_sts.le_minq      = w_t_span <= w_minq_num;
    assign o_sts.div_busy     = w_busy;
    assign o_sts.g_gt         = w_g256 > DivW'(r_t);
    assign o_sts.g_lt         = w_g256 < DivW'(r_t);
    assign o_sts.bounds_close = (r_high - r_low) <= 32'd1;
    assign o_sts.loop_ok      = r_low <= r_high;
    assign o_sts.orl_zero     = r_orl == '0;
    assign o_sts.oc_ge_orl    = r_oc >= r_orl;

    assign o_prescaler   = r_psc;
    assign o_reload      = r_arr;
    assign o_new_compare = (r_orl == '0) ? '0 : ((r_oc >= r_orl) ? r_arr : r_cmp);
endmodule

// ----- hw/rtl/pwm_prescaler_reload_solver_unit.sv -----
// ----------------------------------------------------------------------------
// pwm_prescaler_reload_solver_unit: timer prescaler and reload solver
// Picks prescaler/reload for a target PWM frequency and rescales compare.
// ----------------------------------------------------------------------------
// usage:
//   write i_cfg_we/i_cfg_wdata with the timer clock in hertz while idle
//   in_ch carries one item: target_freq (Q32.8 Hz), old_compare, old_reload
//   out_ch returns one item: prescaler, reload, new_compare
// timing:
//   one item at a time; the shared serial divider sets the pace, each
//   division taking a start state and a wait state in the sequencer;
//   fast/max cases use no division, the slow case one, the search one
//   per iteration (up to SearchLimit) plus one for reload unless exact;
//   compare rescale adds one more where old_reload exceeds old_compare
// reset:
//   clears the sequencer and sets the clock register to zero
// stall:
//   the result holds on out_ch until taken; no new item is accepted
//   before that
// ----------------------------------------------------------------------------
module pwm_prescaler_reload_solver_unit #(
    parameter int COUNTER_BITS = pps_pkg::CounterBitsDef
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pps_pkg::ClkW-1:0] i_cfg_wdata,
    pps_if.sink                      in_ch,
    pps_if.source                    out_ch
);
    import pps_pkg::*;

    logic [ClkW-1:0] r_clk_hz;
    t_cmd            w_cmd;
    t_status         w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clk_hz <= '0;
        else if (i_cfg_we) r_clk_hz <= i_cfg_wdata;
    end

    pps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pps_dp #(.COUNTER_BITS(COUNTER_BITS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clk_hz      (r_clk_hz),
        .i_target_freq (in_ch.data.target_freq),
        .i_old_compare (in_ch.data.old_compare),
        .i_old_reload  (in_ch.data.old_reload),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_prescaler   (out_ch.data.prescaler),
        .o_reload      (out_ch.data.reload),
        .o_new_compare (out_ch.data.new_compare)
    );
endmodule

// ----- verif/tb_pps_types_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_pps_types_pkg: item types for the solver testbench
// Payload layouts of the request and result channels.
// ----------------------------------------------------------------------------
package tb_pps_types_pkg;

    typedef struct packed {
        logic [pps_pkg::FreqW-1:0] target_freq;
        logic [pps_pkg::ValW-1:0]  old_compare;
        logic [pps_pkg::ValW-1:0]  old_reload;
    } t_freq_req;

    typedef struct packed {
        logic [pps_pkg::ValW-1:0] prescaler;
        logic [pps_pkg::ValW-1:0] reload;
        logic [pps_pkg::ValW-1:0] new_compare;
    } t_timer_setting;

endpackage

// ----- verif/pps_solver_checker.sv -----
// ----------------------------------------------------------------------------
// pps_solver_checker: prescaler/reload prediction and result compare
// Watches the config port and both channels, computes the expected timer
// setting for every accepted request and compares it with the result.
// ----------------------------------------------------------------------------
module pps_solver_checker
    import tb_pps_types_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pps_pkg::ClkW-1:0] i_cfg_wdata,
    pps_if                           in_ch,
    pps_if                           out_ch,
    output int                       o_mismatches,
    output int                       o_pending
);

    logic [31:0]    timer_clk_hz;
    t_timer_setting expected_settings[$];

    function automatic logic [63:0] reload_of(logic [63:0] c, logic [63:0] t,
                                              logic [63:0] psc);
        logic [63:0] q;
        q = (c << 8) / (t * (psc + 1));
        return (q - 1) & 64'hFFFF;
    endfunction

    function automatic t_timer_setting solve_setting(logic [31:0] clk_hz, t_freq_req req);
        logic [63:0]    c, t, minq, slowc, q, p, psc, arr, g256, cmp;
        logic [31:0]    lo, hi, mid;
        int             n;
        bit             done;
        t_timer_setting s;
        c     = 64'(clk_hz);
        t     = 64'(req.target_freq);
        minq  = ((c << 8) >> 16) / 65538;
        slowc = c >> 16;
        lo    = 32'd0;
        hi    = 32'hFFFF;
        done  = 0;
        psc   = 0;
        arr   = 0;
        if (t >= (c / 10) * 256) begin
            psc = 0;
            arr = 9;
        end else if (t <= slowc * 256) begin
            if (t <= minq) begin
                psc = 64'hFFFF;
                arr = 64'hFFFF;
            end else begin
                q   = c / (t * 256);
                p   = (q >= 1) ? q - 1 : 0;
                psc = (p > 64'hFFFF) ? 64'hFFFF : p;
                arr = 64'hFFFF;
            end
        end else begin
            for (n = 0; n < pps_pkg::SearchLimit && !done && lo <= hi; n++) begin
                mid  = 32'((64'(lo) + 64'(hi)) >> 1);
                g256 = (slowc / (64'(mid) + 1)) * 256;
                if (g256 > t) begin
                    lo = mid + 1;
                end else if (g256 < t) begin
                    hi = mid - 1;
                end else begin
                    psc  = 64'(mid & 32'hFFFF);
                    arr  = 64'hFFFF;
                    done = 1;
                end
                if (!done && (hi - lo) <= 1) begin
                    psc  = 64'(lo & 32'hFFFF);
                    arr  = reload_of(c, t, psc);
                    done = 1;
                end
            end
            if (!done) begin
                psc = 64'(hi & 32'hFFFF);
                arr = reload_of(c, t, psc);
            end
        end
        // keep duty ratio, clamped to full
        if (req.old_reload == 0) begin
            cmp = 0;
        end else if (req.old_compare >= req.old_reload) begin
            cmp = arr;
        end else begin
            cmp = (arr * 64'(req.old_compare)) / 64'(req.old_reload);
        end
        s.prescaler   = psc[15:0];
        s.reload      = arr[15:0];
        s.new_compare = cmp[15:0];
        return s;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch %s", msg);
        o_mismatches++;
    endtask

    assign o_pending = expected_settings.size();

    always @(posedge i_clk) begin
        t_timer_setting want, got;
        if (!i_rst_n) begin
            timer_clk_hz <= '0;
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                timer_clk_hz <= i_cfg_wdata;
            end
            if (in_ch.valid && in_ch.ready) begin
                expected_settings.push_back(solve_setting(timer_clk_hz, in_ch.data));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_settings.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item %h", got));
                end else begin
                    want = expected_settings.pop_front();
                    if (got.prescaler !== want.prescaler)
                        report_mismatch($sformatf("prescaler: got %h expected %h",
                                                  got.prescaler, want.prescaler));
                    if (got.reload !== want.reload)
                        report_mismatch($sformatf("reload: got %h expected %h",
                                                  got.reload, want.reload));
                    if (got.new_compare !== want.new_compare)
                        report_mismatch($sformatf("new_compare: got %h expected %h",
                                                  got.new_compare, want.new_compare));
                end
            end
        end
    end

endmodule

// ----- verif/tb_pwm_prescaler_reload_solver_unit.sv -----
// ----------------------------------------------------------------------------
// tb_pwm_prescaler_reload_solver_unit: solver testbench top
// Drives timer clock settings and frequency requests with random idling and
// stalls; a separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_pwm_prescaler_reload_solver_unit;
    import tb_pps_types_pkg::*;

    localparam int WatchdogLimit = 20000;
    localparam int RecvHoldLen   = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    int          mismatches;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_seq;
    int          quiet_cycles;

    pps_if #(.T(t_freq_req))      in_ch ();
    pps_if #(.T(t_timer_setting)) out_ch ();

    pwm_prescaler_reload_solver_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    pps_solver_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver side, with its own long hold-off counter
    initial begin
        int hold_seen;
        int recv_hold_cycles;
        hold_seen        = 0;
        recv_hold_cycles = 0;
        out_ch.ready     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen        = hold_seq;
                recv_hold_cycles = RecvHoldLen;
            end
            if (recv_hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                recv_hold_cycles--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog: no progress, pending %0d", pending);
            $display("** pwm_prescaler_reload_solver_unit: FAILED **");
            $finish;
        end
    end

    task automatic send_request(logic [39:0] freq, logic [15:0] cmp, logic [15:0] rld);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid            = 1'b1;
        in_ch.data.target_freq = freq;
        in_ch.data.old_compare = cmp;
        in_ch.data.old_reload  = rld;
        #1;
        while (!in_ch.ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_timer_clock(logic [31:0] hz);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = hz;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // mostly the search band, plus slow, fast, wide and tiny requests
    function automatic logic [39:0] pick_freq(logic [31:0] hz);
        logic [63:0] fast_lim, slow_lim, r64;
        int          r;
        fast_lim = (64'(hz) / 10) * 256;
        slow_lim = (64'(hz) >> 16) * 256;
        r64      = {$urandom, $urandom};
        r        = $urandom_range(99);
        if (r < 55 && fast_lim > slow_lim + 1)
            return 40'(slow_lim + 1 + r64 % (fast_lim - slow_lim - 1));
        else if (r < 70)
            return 40'(r64 % (slow_lim + 1));
        else if (r < 80)
            return 40'(fast_lim + $urandom_range(3) - 1);
        else if (r < 90)
            return r64[39:0];
        else
            return 40'($urandom_range(1000));
    endfunction

    task automatic send_random(logic [31:0] hz);
        logic [15:0] cmp, rld;
        int          r;
        r   = $urandom_range(9);
        rld = (r == 0) ? 16'h0 : 16'($urandom);
        cmp = (r == 1) ? rld + 16'($urandom_range(5)) : 16'($urandom);
        send_request(pick_freq(hz), cmp, rld);
    endtask

    logic [31:0] clk_settings[7] = '{32'd72_000_000, 32'd0, 32'hFFFF_FFFF, 32'd1,
                                     32'd16_000_000, 32'd0, 32'd170_000_000};

    initial begin
        logic [63:0] c, fast_lim, slow_lim, minq;
        int          k, n;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        send_idle_pct    = 38;
        recv_idle_pct    = 67;
        hold_seq         = 0;
        clk_settings[5]  = $urandom;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (k = 0; k < 7; k++) begin
            if (k == 3) begin
                send_idle_pct = 67;
                recv_idle_pct = 38;
            end else if (k == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_timer_clock(clk_settings[k]);
            c        = clk_settings[k];
            fast_lim = (c / 10) * 256;
            slow_lim = (c >> 16) * 256;
            minq     = ((c << 8) >> 16) / 65538;
            if (k == 0 || k == 2) begin
                // band edges and duty corner cases
                send_request(40'd0, 16'd0, 16'd0);
                send_request(40'd1, 16'hFFFF, 16'hFFFF);
                send_request(40'(minq), 16'hFFFF, 16'd1);
                send_request(40'(minq + 1), 16'd1, 16'hFFFF);
                send_request(40'(slow_lim), 16'd5, 16'd0);
                send_request(40'(slow_lim + 1), 16'd100, 16'd200);
                send_request(40'(fast_lim - 1), 16'd200, 16'd100);
                send_request(40'(fast_lim), 16'h8000, 16'hFFFF);
                send_request(40'hFF_FFFF_FFFF, 16'h1234, 16'h4321);
                send_request(40'd256, 16'd3, 16'd7);
                send_request(40'd512, 16'hFFFE, 16'hFFFF);
                send_request(40'(slow_lim / 2), 16'd10, 16'd20);
            end
            for (n = 0; n < 100; n++) begin
                if (k == 0 && n == 10) hold_seq++;
                if (k == 1 && n == 50) drain_results();
                send_random(clk_settings[k]);
            end
        end
        drain_results();
        repeat (100) @(negedge i_clk);
        if (mismatches == 0)
            $display("** pwm_prescaler_reload_solver_unit: PASSED **");
        else
            $display("** pwm_prescaler_reload_solver_unit: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pps_pkg.sv
hw/rtl/pps_if.sv
hw/rtl/pps_div.sv
hw/rtl/pps_ctrl.sv
hw/rtl/pps_dp.sv
hw/rtl/pwm_prescaler_reload_solver_unit.sv
verif/tb_pps_types_pkg.sv
verif/pps_solver_checker.sv
verif/tb_pwm_prescaler_reload_solver_unit.sv
